### rtl/bbre_pkg.sv
package bbre_pkg;

    localparam int UNIT_BYTES = 8;

    localparam int ALPHA_W = 7;
    localparam int BYTE_W  = 8;
    localparam int DIGIT_W = 16;
    localparam int ACC_W   = 64;
    localparam int CNT_W   = 4;

    // job queue between front and back, depth a power of two
    localparam int JOB_DEPTH = 2;
    localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_message;
    } item_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               unit_last;
        logic               message_last;
    } result_t;

    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic [CNT_W-1:0] nbytes;
        logic             eom;
    } job_t;

endpackage

### rtl/bbre_front.sv
module bbre_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bbre_pkg::item_t item,
    output logic            full,
    input  logic            job_full,
    output logic            job_push,
    output bbre_pkg::job_t  job
);
    import bbre_pkg::*;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W-1:0] acc_merged;
    logic [CNT_W-1:0] cnt_inc;
    logic             accept;
    logic             close;

    assign full   = job_full;
    assign accept = push && !job_full;

    assign acc_merged = acc_reg | (ACC_W'(item.data_byte) << {cnt_reg[2:0], 3'b000});
    assign cnt_inc    = cnt_reg + CNT_W'(1);
    assign close      = (cnt_inc >= CNT_W'(UNIT_BYTES)) || item.end_of_message;

    assign job_push   = accept && close;
    assign job.value  = acc_merged;
    assign job.nbytes = cnt_inc;
    assign job.eom    = item.end_of_message;

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (close)
            begin
                acc_next = '0;
                cnt_next = '0;
            end
            else
            begin
                acc_next = acc_merged;
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### rtl/bbre_job_queue.sv
module bbre_job_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bbre_pkg::job_t din,
    output logic           full,
    input  logic           pop,
    output bbre_pkg::job_t dout,
    output logic           empty
);
    import bbre_pkg::*;

    job_t                 mem_reg [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JOB_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JOB_PTR_W:0]   count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == (JOB_PTR_W+1)'(JOB_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + JOB_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + JOB_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (JOB_PTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (JOB_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/bbre_back.sv
module bbre_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [bbre_pkg::DIGIT_W-1:0]   base,
    input  logic                           job_empty,
    input  bbre_pkg::job_t                 job,
    output logic                           job_pop,
    output logic                           empty,
    input  logic                           pop,
    output bbre_pkg::result_t              result
);
    import bbre_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    localparam int STEP_W = $clog2(ACC_W);

    state_t             state_reg, state_next;
    logic [ACC_W-1:0]   val_reg, val_next;
    logic [ACC_W-1:0]   lim_reg, lim_next;
    logic [DIGIT_W-1:0] remv_reg, remv_next;
    logic [DIGIT_W-1:0] reml_reg, reml_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               eom_reg, eom_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic [DIGIT_W:0]   trial_v, trial_l;
    logic               qbit_v, qbit_l;
    logic [ACC_W-1:0]   job_limit;
    logic               out_free;
    logic               lim_zero;

    // restoring division, one quotient bit per cycle, value and limit in lockstep
    assign trial_v = {remv_reg, val_reg[ACC_W-1]};
    assign trial_l = {reml_reg, lim_reg[ACC_W-1]};
    assign qbit_v  = (trial_v >= {1'b0, base});
    assign qbit_l  = (trial_l >= {1'b0, base});

    // largest value an n-byte unit can hold
    assign job_limit = (job.nbytes >= CNT_W'(8)) ? '1
                     : ((ACC_W'(1) << {job.nbytes[2:0], 3'b000}) - ACC_W'(1));

    assign out_free = !out_valid_reg || pop;
    assign lim_zero = (lim_reg == '0);
    assign job_pop  = (state_reg == ST_IDLE) && !job_empty;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        val_next       = val_reg;
        lim_next       = lim_reg;
        remv_next      = remv_reg;
        reml_next      = reml_reg;
        step_next      = step_reg;
        eom_next       = eom_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    val_next   = job.value;
                    lim_next   = job_limit;
                    eom_next   = job.eom;
                    remv_next  = '0;
                    reml_next  = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                val_next  = {val_reg[ACC_W-2:0], qbit_v};
                lim_next  = {lim_reg[ACC_W-2:0], qbit_l};
                remv_next = qbit_v ? DIGIT_W'(trial_v - {1'b0, base}) : trial_v[DIGIT_W-1:0];
                reml_next = qbit_l ? DIGIT_W'(trial_l - {1'b0, base}) : trial_l[DIGIT_W-1:0];
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ACC_W-1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // remv holds the digit, lim the reduced limit
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.digit        = remv_reg;
                    out_next.unit_last    = lim_zero;
                    out_next.message_last = lim_zero && eom_reg;
                    remv_next             = '0;
                    reml_next             = '0;
                    step_next             = '0;
                    state_next            = lim_zero ? ST_IDLE : ST_DIV;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        lim_reg  <= lim_next;
        remv_reg <= remv_next;
        reml_reg <= reml_next;
        eom_reg  <= eom_next;
        out_reg  <= out_next;
    end

endmodule

### rtl/byte_block_radix_encoder_unit.sv
// Flow: a closing byte's job passes through the job queue to the back end; each digit
//   then takes the 64-step bit-serial divider plus an emit state, so a unit of k digits
//   makes k such passes to its last digit (k up to 21 for 8 bytes, base 9).
// Throughput: one byte per cycle unless job queue is full; divider sets the unit rate.
// Reset (rst_n, async low) empties the unit, the job queue and the output; alpha = 1.
module byte_block_radix_encoder_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  bbre_pkg::item_t                 item,
    output logic                            full,
    output logic                            empty,
    input  logic                            pop,
    output bbre_pkg::result_t               result,
    input  logic                            cfg_we,
    input  logic [bbre_pkg::ALPHA_W-1:0]    cfg_data
);
    import bbre_pkg::*;

    logic [ALPHA_W-1:0] alpha_reg;
    logic [DIGIT_W-1:0] base_reg, base_next;
    logic [ALPHA_W-1:0] alpha_eff;
    logic [ALPHA_W:0]   radix;

    logic job_push, job_full, job_pop, job_empty;
    job_t job_in, job_out;

    // alpha of zero falls back to base 9
    assign alpha_eff = (alpha_reg == '0) ? ALPHA_W'(1) : alpha_reg;
    assign radix     = {alpha_eff, 1'b1};
    assign base_next = DIGIT_W'(radix) * DIGIT_W'(radix);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_W'(1);
            base_reg  <= DIGIT_W'(9);
        end
        else
        begin
            if (cfg_we)
            begin
                alpha_reg <= cfg_data;
            end
            base_reg <= base_next;
        end
    end

    bbre_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .job_full (job_full),
        .job_push (job_push),
        .job      (job_in)
    );

    bbre_job_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .dout  (job_out),
        .empty (job_empty)
    );

    bbre_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .base      (base_reg),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
